// ===== rtl/core/global_edf_tick_scheduler_top_assert.svh =====
// ---------------------------------------------------------------------------
// global edf tick scheduler assertion macros
// property shorthands for the port-level checker, clocked on i_clk,
// disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef GLOBAL_EDF_TICK_SCHEDULER_TOP_ASSERT_SVH
`define GLOBAL_EDF_TICK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define GETS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GETS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gets_pkg.sv =====
// ---------------------------------------------------------------------------
// gets_pkg
// shared types and constants of the global edf tick scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package gets_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TASK_W     = 4;
    localparam int PROC_SLOTS = 4;
    localparam int PROC_W     = 2;

    localparam logic [4:0]  IDLE_CODE = 5'd16;
    localparam logic [2:0]  NO_PROC   = 3'd7;
    localparam logic [19:0] OVR_MAX   = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  task_number;
        logic [15:0] exec_time;
        logic [15:0] task_period;
    } t_item;

    typedef struct packed {
        logic [4:0]  proc0_task;
        logic [4:0]  proc1_task;
        logic [4:0]  proc2_task;
        logic [4:0]  proc3_task;
        logic        scheduler_ran;
        logic [4:0]  jobs_released;
        logic [2:0]  switches_now;
        logic [4:0]  misses_now;
        logic [19:0] overrun_now;
        logic [31:0] task_misses;
        logic [31:0] task_overrun;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic              accept;
        logic              load;
        logic              scan;
        logic              init;
        logic              order;
        logic              fill;
        logic              decr;
        logic              flush;
        logic              finish;
        logic [TASK_W-1:0] idx;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic sched;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/gets_ctrl.sv =====
// ---------------------------------------------------------------------------
// gets_ctrl
// sequencer of the scheduler: walks tasks and processors per operation
// ---------------------------------------------------------------------------
`default_nettype none

module gets_ctrl #(
    parameter int PROCESSORS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  gets_pkg::t_op  i_op,
    input  gets_pkg::t_sts i_sts,
    output gets_pkg::t_ctl o_ctl,
    output logic           o_busy
);
    import gets_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_INIT   = 9'b000001000,
        S_ORDER  = 9'b000010000,
        S_FILL   = 9'b000100000,
        S_DECR   = 9'b001000000,
        S_FLUSH  = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    localparam logic [TASK_W-1:0] TASK_LAST = TASK_W'(MAX_TASKS - 1);
    localparam logic [PROC_W-1:0] PROC_LAST = PROC_W'(PROCESSORS - 1);

    t_state            r_state, n_state;
    logic [TASK_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctl   = '0;
        o_ctl.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.accept = i_start;
                n_idx = '0;
                if (i_start) begin
                    unique case (i_op)
                        OP_LOAD:  n_state = S_LOAD;
                        OP_TICK:  n_state = S_SCAN;
                        OP_FLUSH: n_state = S_FLUSH;
                        OP_READ:  n_state = S_FINISH;
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_LOAD: begin
                o_ctl.load = 1'b1;
                n_state = S_FINISH;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == TASK_LAST) begin
                    n_idx   = '0;
                    n_state = i_sts.sched ? S_INIT : S_DECR;
                end
            end
            S_INIT: begin
                o_ctl.init = 1'b1;
                n_idx   = '0;
                n_state = S_ORDER;
            end
            S_ORDER: begin
                o_ctl.order = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == TASK_LAST) begin
                    n_idx   = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_ctl.fill = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx[PROC_W-1:0] == PROC_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_DECR: begin
                o_ctl.decr = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx[PROC_W-1:0] == PROC_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FLUSH: begin
                o_ctl.flush = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == TASK_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/gets_dpath.sv =====
// ---------------------------------------------------------------------------
// gets_dpath
// task tables, statistics, ranking lanes and processor assignment
// ---------------------------------------------------------------------------
`default_nettype none

module gets_dpath #(
    parameter int PROCESSORS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gets_pkg::t_item   i_cmd,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_data,
    input  gets_pkg::t_ctl    i_ctl,
    output gets_pkg::t_sts    o_sts,
    output gets_pkg::t_result o_result,
    output logic              o_done
);
    import gets_pkg::*;

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    // configuration and latched word
    logic [4:0]  r_cfg;
    t_item       r_item;

    // per-task state
    logic [15:0] r_exec   [MAX_TASKS];
    logic [15:0] r_period [MAX_TASKS];
    logic [15:0] r_phase  [MAX_TASKS];
    logic [15:0] r_rem    [MAX_TASKS];
    logic [31:0] r_miss   [MAX_TASKS];
    logic [31:0] r_ovr    [MAX_TASKS];
    logic        r_done   [MAX_TASKS];
    logic [2:0]  r_lastp  [MAX_TASKS];
    logic [TASK_W-1:0] r_rank  [MAX_TASKS];
    logic [TASK_W-1:0] r_order [MAX_TASKS];
    logic        r_used   [MAX_TASKS];

    // per-processor state
    logic [4:0]  r_holder [PROC_SLOTS];
    logic        r_busy   [PROC_SLOTS];
    logic [4:0]  r_ready;
    logic [31:0] r_tick;

    // per-operation accumulators
    logic        r_sched;
    logic [4:0]  r_rel;
    logic [2:0]  r_sw;
    logic [4:0]  r_mcnt;
    logic [19:0] r_ovrn;
    t_result     r_res;
    logic        r_strobe;

    logic [4:0]  w_n;
    logic [16:0] w_key [MAX_TASKS];
    logic        w_before [MAX_TASKS];

    logic [TASK_W-1:0] w_j;
    logic        w_in_j, w_rel_j, w_done_rel, w_fin_j, w_miss_en;
    logic [15:0] w_rem_j, w_rem_rel;
    logic [20:0] w_ovr_sum;

    logic [TASK_W-1:0] w_t;
    logic        w_k_ok;

    logic [PROC_W-1:0] w_p;
    logic        w_p_ok, w_found, w_sw;
    logic [MAX_TASKS-1:0] w_elig;
    logic [TASK_W-1:0] w_kf, w_t2, w_h_t;
    logic [4:0]  w_h;

    logic [4:0]  w_init_hold [PROC_SLOTS];
    t_result     w_res;

    assign w_n = (r_cfg > 5'(MAX_TASKS)) ? 5'(MAX_TASKS) : r_cfg;

    // distance to next release, zero period ranks last
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_key[i] = (r_period[i] == 16'd0) ? 17'h10000
                                               : {1'b0, r_period[i] - r_phase[i]};
        end
    end

    // release scan of task idx
    always_comb begin
        w_j        = i_ctl.idx;
        w_in_j     = ({1'b0, w_j} < w_n);
        w_rem_j    = r_rem[w_j];
        w_rel_j    = w_in_j && (r_period[w_j] != 16'd0) && (r_phase[w_j] == 16'd0);
        w_rem_rel  = w_rel_j ? r_exec[w_j] : w_rem_j;
        w_done_rel = w_rel_j ? 1'b0 : r_done[w_j];
        w_fin_j    = w_in_j && (w_rem_rel == 16'd0) && !w_done_rel;
        w_miss_en  = ((i_ctl.scan && w_rel_j) || (i_ctl.flush && w_in_j)) &&
                     (w_rem_j != 16'd0);
        w_ovr_sum  = {1'b0, r_ovrn} + {5'd0, w_rem_j};
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_before[i] = (w_key[w_j] < w_key[i]) ||
                          ((w_key[w_j] == w_key[i]) && (w_j < TASK_W'(i)));
        end
    end

    assign o_sts.sched = r_sched || w_rel_j || w_fin_j;

    // task at rank idx
    always_comb begin
        w_t    = '0;
        w_k_ok = ({1'b0, i_ctl.idx} < w_n);
        for (int i = 0; i < MAX_TASKS; i++) begin
            if ((5'(i) < w_n) && (r_rank[i] == i_ctl.idx)) begin
                w_t = TASK_W'(i);
            end
        end
    end

    // best unassigned unfinished task for processor idx
    always_comb begin
        w_p    = i_ctl.idx[PROC_W-1:0];
        w_p_ok = ({1'b0, w_p} < 3'(PROCESSORS));
        for (int k = 0; k < MAX_TASKS; k++) begin
            w_elig[k] = (5'(k) < w_n) && !r_used[r_order[k]] && !r_done[r_order[k]];
        end
        w_found = |w_elig;
        w_kf    = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (w_elig[k]) begin
                w_kf = TASK_W'(k);
            end
        end
        w_t2  = r_order[w_kf];
        w_h   = r_holder[w_p];
        w_h_t = w_h[TASK_W-1:0];
        w_sw  = !w_h[4] && (r_rem[w_h_t] != 16'd0) &&
                ((r_period[w_h_t] == 16'd0) || (r_phase[w_h_t] != 16'd0));
    end

    // running tasks reclaim their processor, last index wins
    always_comb begin
        for (int p = 0; p < PROC_SLOTS; p++) begin
            w_init_hold[p] = r_holder[p];
            for (int i = 0; i < MAX_TASKS; i++) begin
                if ((5'(i) < w_n) && (r_lastp[i] == 3'(p)) && (p < PROCESSORS)) begin
                    w_init_hold[p] = 5'(i);
                end
            end
        end
    end

    always_comb begin
        w_res = '0;
        w_res.proc0_task = (0 < PROCESSORS) ? r_holder[0] : IDLE_CODE;
        w_res.proc1_task = (1 < PROCESSORS) ? r_holder[1] : IDLE_CODE;
        w_res.proc2_task = (2 < PROCESSORS) ? r_holder[2] : IDLE_CODE;
        w_res.proc3_task = (3 < PROCESSORS) ? r_holder[3] : IDLE_CODE;
        w_res.scheduler_ran = (r_item.operation == OP_TICK) && r_sched;
        w_res.jobs_released = r_rel;
        w_res.switches_now  = r_sw;
        w_res.misses_now    = r_mcnt;
        w_res.overrun_now   = r_ovrn;
        if (r_item.operation == OP_READ) begin
            w_res.task_misses  = r_miss[r_item.task_number];
            w_res.task_overrun = r_ovr[r_item.task_number];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= 5'd1;
            r_tick   <= '0;
            r_ready  <= '0;
            r_sched  <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_phase[i] <= '0;
                r_rem[i]   <= '0;
                r_miss[i]  <= '0;
                r_ovr[i]   <= '0;
                r_done[i]  <= 1'b0;
                r_lastp[i] <= NO_PROC;
                r_used[i]  <= 1'b0;
            end
            for (int p = 0; p < PROC_SLOTS; p++) begin
                r_holder[p] <= IDLE_CODE;
                r_busy[p]   <= 1'b0;
            end
        end else begin
            r_strobe <= i_ctl.finish;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            if (i_ctl.accept) begin
                r_item  <= i_cmd;
                r_sched <= 1'b0;
                r_rel   <= '0;
                r_sw    <= '0;
                r_mcnt  <= '0;
                r_ovrn  <= '0;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    r_rank[i] <= '0;
                end
            end

            // restart of time after a table write
            if (i_ctl.load) begin
                r_exec[r_item.task_number]   <= r_item.exec_time;
                r_period[r_item.task_number] <= r_item.task_period;
                r_tick <= '0;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    r_phase[i] <= '0;
                    r_rem[i]   <= '0;
                    r_miss[i]  <= '0;
                    r_ovr[i]   <= '0;
                    r_done[i]  <= 1'b0;
                    r_lastp[i] <= NO_PROC;
                end
                for (int p = 0; p < PROC_SLOTS; p++) begin
                    r_holder[p] <= IDLE_CODE;
                end
            end

            if (i_ctl.scan) begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (w_in_j && w_before[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rem[w_j]  <= w_rem_rel;
                r_done[w_j] <= w_done_rel || w_fin_j;
                if (w_rel_j) begin
                    r_rel <= r_rel + 1'b1;
                end
                r_sched <= o_sts.sched;
            end

            if (i_ctl.flush && w_in_j) begin
                r_rem[w_j] <= '0;
            end

            if (w_miss_en) begin
                r_miss[w_j] <= sat32(r_miss[w_j], 32'd1);
                r_ovr[w_j]  <= sat32(r_ovr[w_j], {16'd0, w_rem_j});
                r_mcnt      <= r_mcnt + 1'b1;
                r_ovrn      <= w_ovr_sum[20] ? OVR_MAX : w_ovr_sum[19:0];
            end

            if (i_ctl.init) begin
                r_ready <= '0;
                for (int p = 0; p < PROC_SLOTS; p++) begin
                    r_holder[p] <= w_init_hold[p];
                    r_busy[p]   <= 1'b0;
                end
                for (int i = 0; i < MAX_TASKS; i++) begin
                    r_used[i] <= 1'b0;
                    if (!((5'(i) < w_n) && (r_lastp[i] < 3'(PROCESSORS)))) begin
                        r_lastp[i] <= NO_PROC;
                    end
                end
            end

            // keep-or-drop pass in deadline order
            if (i_ctl.order && w_k_ok) begin
                r_order[i_ctl.idx] <= w_t;
                if (r_rem[w_t] != 16'd0) begin
                    if ((r_lastp[w_t] != NO_PROC) && (r_ready < 5'(PROCESSORS))) begin
                        r_rem[w_t] <= r_rem[w_t] - 1'b1;
                        r_busy[r_lastp[w_t][PROC_W-1:0]] <= 1'b1;
                        r_used[w_t] <= 1'b1;
                    end else begin
                        r_lastp[w_t] <= NO_PROC;
                    end
                    r_ready <= r_ready + 1'b1;
                end else begin
                    r_lastp[w_t] <= NO_PROC;
                end
            end

            if (i_ctl.fill && w_p_ok && !r_busy[w_p]) begin
                if (w_found) begin
                    if (w_sw) begin
                        r_sw <= r_sw + 1'b1;
                    end
                    r_holder[w_p] <= {1'b0, w_t2};
                    r_lastp[w_t2] <= {1'b0, w_p};
                    if (r_rem[w_t2] != 16'd0) begin
                        r_rem[w_t2] <= r_rem[w_t2] - 1'b1;
                    end
                    r_used[w_t2] <= 1'b1;
                    r_busy[w_p]  <= 1'b1;
                end else begin
                    r_holder[w_p] <= IDLE_CODE;
                end
            end

            if (i_ctl.decr && w_p_ok && !w_h[4] && (r_rem[w_h_t] != 16'd0)) begin
                r_rem[w_h_t] <= r_rem[w_h_t] - 1'b1;
            end

            if (i_ctl.finish) begin
                r_res <= w_res;
                if (r_item.operation == OP_TICK) begin
                    r_tick <= r_tick + 1'b1;
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if ((r_tick == 32'hFFFFFFFF) ||
                            ((r_phase[i] + 1'b1) == r_period[i])) begin
                            r_phase[i] <= '0;
                        end else begin
                            r_phase[i] <= r_phase[i] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_result = r_res;
    assign o_done   = r_strobe;

endmodule

`default_nettype wire

// ===== rtl/core/global_edf_tick_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// global_edf_tick_scheduler_top
// global earliest-deadline-first scheduler for periodic tasks, one tick per word
// ---------------------------------------------------------------------------
// A word is taken when i_start is high while o_busy is low; its result shows on
// o_result for one cycle with o_done and must be captured then, since the
// receiver cannot stall. The sequencer walks the sixteen task slots one per
// cycle (release scan with ranking lanes, then the keep pass in deadline
// order) and the processors one per cycle. Only one word is in flight.
// task_count is written over the cfg channel, which is always ready; write it
// only while o_busy is low.
`default_nettype none

module global_edf_tick_scheduler_top #(
    parameter int PROCESSORS = 4   // processors scheduled, 1 to 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_start,
    output logic              o_busy,
    input  gets_pkg::t_item   i_cmd,
    // result strobe
    output logic              o_done,
    output gets_pkg::t_result o_result,
    // task_count register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [4:0]        i_cfg_data
);
    import gets_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // user writes the register only while idle, unchecked by the block, so never hold the channel off
    assign o_cfg_ready = 1'b1;

    gets_ctrl #(
        .PROCESSORS(PROCESSORS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_cmd.operation),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (o_busy)
    );

    gets_dpath #(
        .PROCESSORS(PROCESSORS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gets_checker.sv =====
// ---------------------------------------------------------------------------
// gets_checker
// port-level checks of the scheduler command and result timing
// ---------------------------------------------------------------------------
`default_nettype none

`include "global_edf_tick_scheduler_top_assert.svh"

module gets_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input gets_pkg::t_result o_result
);
    import gets_pkg::*;

    `GETS_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "no busy after accept")
    `GETS_ASSERT_NOW(a_done_idle, o_done, !o_busy, "result strobe while busy")
    `GETS_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than a cycle")
    `GETS_ASSERT_NOW(a_switch_ran, o_done && (o_result.switches_now != 3'd0),
        o_result.scheduler_ran, "switches without a scheduler run")

endmodule

bind global_edf_tick_scheduler_top gets_checker u_gets_checker (.*);

`default_nettype wire
